/* rtl/icmp_echo_responder_assert.svh */
// Assertion macros for the ICMP echo responder.
`ifndef ICMP_ECHO_RESPONDER_ASSERT_SVH
`define ICMP_ECHO_RESPONDER_ASSERT_SVH
`ifndef SYNTHESIS
`define IER_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ier: invariant violated");
`define IER_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ier: same-cycle implication violated");
`define IER_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ier: next-cycle implication violated");
`else
`define IER_ASSERT(lbl, clk, rstn, prop)
`define IER_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define IER_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/ier_pkg.sv */
package ier_pkg;

  localparam int HdrBytes  = 20;
  localparam int HdrIdxW   = $clog2(HdrBytes);
  localparam int MinIcmp   = 8;
  localparam int LeadBytes = 4;
  localparam int LeadIdxW  = $clog2(LeadBytes);
  // Second byte of the header checksum word.
  localparam int ChkWordEnd = 11;
  // Shortest total length at which an odd trailing ICMP byte is padded.
  localparam int OddPadMin  = HdrBytes + 5;
  localparam logic [3:0] IpVersion    = 4'd4;
  localparam logic [7:0] ProtoIcmp    = 8'd1;
  localparam logic [7:0] TypeEchoReq  = 8'd8;
  localparam logic [3:0] McastNibble  = 4'he;

  typedef logic [HdrBytes-1:0][7:0] hdr_t;

  typedef enum logic [3:0] {
    StOk      = 4'd0,
    StShort   = 4'd1,
    StVersion = 4'd2,
    StLen     = 4'd3,
    StTrunc   = 4'd4,
    StHlen    = 4'd5,
    StIpSum   = 4'd6,
    StProto   = 4'd7,
    StFrag    = 4'd8,
    StSrc     = 4'd9,
    StMcast   = 4'd10,
    StIcmpSum = 4'd11,
    StType    = 4'd12,
    StCode    = 4'd13
  } status_e;

  // Packet totals captured on the last word.
  typedef struct packed {
    logic [15:0]                 count;
    logic [15:0]                 hdr_sum;
    logic [15:0]                 ip_sum;
    logic [15:0]                 icmp_sum;
    logic [7:0]                  hold;
    logic [LeadBytes-1:0][7:0]   lead;
  } snap_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ip_chk;
    logic [15:0] icmp_chk;
  } result_t;

  // Ones'-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

/* rtl/icmp_echo_responder.sv */
// Channel   Direction  Handshake               Word
// in        input      in_valid_i / in_stall_o   data_byte_i, last_byte_i
// out       output     out_valid_o / out_stall_i status_o, reply_* fields
//
// One packet byte is taken in every clock cycle while the input does not stall.
// After its last byte is taken, a verdict passes through the snapshot register into the output queue.
// The input stalls only on a last byte while two verdicts are queued or in flight
// and none leaves in that cycle.
// Reset clears the byte count, the running sums and all valid flags.
`include "icmp_echo_responder_assert.svh"
module icmp_echo_responder import ier_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [31:0] reply_source_o,
  output logic [31:0] reply_destination_o,
  output logic [15:0] reply_ip_checksum_o,
  output logic [15:0] reply_icmp_checksum_o
);

  logic       byte_valid_q, last_q;
  logic [7:0] byte_q;
  logic       fire, pop, blocked;
  logic [1:0] pending;

  logic       snap_valid;
  snap_t      snap;
  hdr_t       hdr;
  result_t    res;

  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  // Verdicts in flight or queued, less the one leaving now.
  assign pop     = out_valid_q && !out_stall_i;
  assign pending = {1'b0, out_valid_q} + {1'b0, skid_valid_q} + {1'b0, snap_valid}
                   - {1'b0, pop};
  assign blocked = pending >= 2'd2;

  assign in_stall_o = byte_valid_q && last_q && blocked;
  assign fire       = byte_valid_q && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  ier_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (byte_q),
    .last_byte_i  (last_q),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .hdr_o        (hdr)
  );

  ier_verdict u_verdict (
    .snap_i   (snap),
    .hdr_i    (hdr),
    .result_o (res)
  );

  // Two-entry output queue: the head drives the ports, the skid catches a stalled push.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= snap_valid;
      end else begin
        out_valid_q  <= snap_valid;
      end
    end else if (snap_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (snap_valid) begin
          skid_q <= res;
        end
      end else if (snap_valid) begin
        out_q <= res;
      end
    end else if (snap_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = out_q.status;
  assign reply_source_o        = out_q.src;
  assign reply_destination_o   = out_q.dst;
  assign reply_ip_checksum_o   = out_q.ip_chk;
  assign reply_icmp_checksum_o = out_q.icmp_chk;

  `IER_ASSERT(a_skid_behind_head, clk_i, rst_ni, !skid_valid_q || out_valid_q)
  `IER_ASSERT(a_no_queue_overrun, clk_i, rst_ni, !(snap_valid && out_valid_q && skid_valid_q))
  `IER_ASSERT_NEXT(a_last_makes_verdict, clk_i, rst_ni, fire && last_q, snap_valid)
  `IER_ASSERT_IMPL(a_stall_only_on_last, clk_i, rst_ni, in_stall_o, byte_valid_q && last_q)

endmodule

/* rtl/ier_accum.sv */
module ier_accum import ier_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       snap_valid_o,
  output snap_t      snap_o,
  output hdr_t       hdr_o
);

  logic [15:0] count_q, hdr_sum_q, ip_sum_q, icmp_sum_q;
  logic [7:0]  hold_q, prev_q;
  logic [LeadBytes-1:0][7:0] lead_q;
  hdr_t        hdr_q, hdr_d;
  snap_t       upd, snap_q;
  logic        snap_valid_q;

  logic [15:0] pos, total_len, off;
  logic        in_hdr, in_icmp;
  logic [15:0] word;

  assign pos       = count_q;
  assign total_len = {hdr_q[2], hdr_q[3]};
  assign in_hdr    = pos < 16'(HdrBytes);
  assign in_icmp   = !in_hdr && (pos < total_len);
  assign off       = pos - 16'(HdrBytes);
  assign word      = {prev_q, data_byte_i};

  always_comb begin
    hdr_d        = hdr_q;
    upd.count    = count_q + {15'd0, (count_q != 16'hffff)};
    upd.hdr_sum  = hdr_sum_q;
    upd.ip_sum   = ip_sum_q;
    upd.icmp_sum = icmp_sum_q;
    upd.hold     = hold_q;
    upd.lead     = lead_q;
    if (in_hdr) begin
      hdr_d[pos[HdrIdxW-1:0]] = data_byte_i;
      if (pos[0]) begin
        upd.hdr_sum = oc_add(hdr_sum_q, word);
        // The reply checksum leaves out the received checksum word.
        if (pos != 16'(ChkWordEnd)) begin
          upd.ip_sum = oc_add(ip_sum_q, word);
        end
      end
    end else if (in_icmp) begin
      if (off < 16'(LeadBytes)) begin
        upd.lead[off[LeadIdxW-1:0]] = data_byte_i;
      end else if (!off[0]) begin
        upd.hold = data_byte_i;
      end else begin
        upd.icmp_sum = oc_add(icmp_sum_q, {hold_q, data_byte_i});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      hdr_sum_q    <= '0;
      ip_sum_q     <= '0;
      icmp_sum_q   <= '0;
      hold_q       <= '0;
      lead_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= fire_i && last_byte_i;
      if (fire_i) begin
        if (last_byte_i) begin
          count_q    <= '0;
          hdr_sum_q  <= '0;
          ip_sum_q   <= '0;
          icmp_sum_q <= '0;
          hold_q     <= '0;
          lead_q     <= '0;
        end else begin
          count_q    <= upd.count;
          hdr_sum_q  <= upd.hdr_sum;
          ip_sum_q   <= upd.ip_sum;
          icmp_sum_q <= upd.icmp_sum;
          hold_q     <= upd.hold;
          lead_q     <= upd.lead;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hdr_q  <= hdr_d;
      prev_q <= data_byte_i;
      if (last_byte_i) begin
        snap_q <= upd;
      end
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;
  assign hdr_o        = hdr_q;

endmodule

/* rtl/ier_verdict.sv */
module ier_verdict import ier_pkg::*; (
  input  snap_t   snap_i,
  input  hdr_t    hdr_i,
  output result_t result_o
);

  logic [15:0] total_len;
  logic [5:0]  hlen;
  logic [16:0] min_len;
  logic [31:0] src, dst;
  logic [15:0] rest, part, full;
  status_e     status;

  assign total_len = {hdr_i[2], hdr_i[3]};
  assign hlen      = {hdr_i[0][3:0], 2'b00};
  assign min_len   = {11'd0, hlen} + 17'(MinIcmp);
  assign src       = {hdr_i[12], hdr_i[13], hdr_i[14], hdr_i[15]};
  assign dst       = {hdr_i[16], hdr_i[17], hdr_i[18], hdr_i[19]};

  always_comb begin
    rest = snap_i.icmp_sum;
    // An odd ICMP length leaves a high byte that is padded with zero.
    if (total_len >= 16'(OddPadMin) && total_len[0]) begin
      rest = oc_add(snap_i.icmp_sum, {snap_i.hold, 8'h00});
    end
  end

  assign part = oc_add(rest, {snap_i.lead[0], snap_i.lead[1]});
  assign full = oc_add(part, {snap_i.lead[2], snap_i.lead[3]});

  always_comb begin
    if (snap_i.count < 16'(HdrBytes))                  status = StShort;
    else if (hdr_i[0][7:4] != IpVersion)               status = StVersion;
    else if ({1'b0, total_len} < min_len)              status = StLen;
    else if (snap_i.count < total_len)                 status = StTrunc;
    else if (hlen != 6'(HdrBytes))                     status = StHlen;
    else if (snap_i.hdr_sum != 16'hffff)               status = StIpSum;
    else if (hdr_i[9] != ProtoIcmp)                    status = StProto;
    else if ((hdr_i[6] | hdr_i[7]) != 8'd0)            status = StFrag;
    else if (src == 32'hffff_ffff || src == 32'd0)     status = StSrc;
    else if (src[31:28] == McastNibble)                status = StMcast;
    else if (full != 16'hffff)                         status = StIcmpSum;
    else if (snap_i.lead[0] != TypeEchoReq)            status = StType;
    else if (snap_i.lead[1] != 8'd0)                   status = StCode;
    else                                               status = StOk;
  end

  always_comb begin
    result_o        = '0;
    result_o.status = status;
    if (status == StOk) begin
      result_o.src      = dst;
      result_o.dst      = src;
      result_o.ip_chk   = ~snap_i.ip_sum;
      // Type becomes zero, so only the code byte stays in the sum.
      result_o.icmp_chk = ~oc_add(rest, {8'd0, snap_i.lead[1]});
    end
  end

endmodule

/* dv/tb_icmp_echo_responder.sv */
module tb_icmp_echo_responder;
  import ier_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int LongHold   = 400;
  localparam int RandBytes  = 300;
  localparam int RandReplies = 8;
  localparam int CountMax   = 65535;

  // Kinds of packets the generator can build.
  typedef enum int {
    PkEcho, PkTrailing, PkShort, PkVersion, PkLen, PkTrunc, PkHlen, PkIpSum,
    PkProto, PkFrag, PkSrc, PkMcast, PkIcmpSum, PkType, PkCode, PkNoise
  } flavor_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ip_chk;
    logic [15:0] icmp_chk;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  status_o;
  logic [31:0] reply_source_o;
  logic [31:0] reply_destination_o;
  logic [15:0] reply_ip_checksum_o;
  logic [15:0] reply_icmp_checksum_o;

  icmp_echo_responder dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .data_byte_i           (data_byte_i),
    .last_byte_i           (last_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .reply_source_o        (reply_source_o),
    .reply_destination_o   (reply_destination_o),
    .reply_ip_checksum_o   (reply_ip_checksum_o),
    .reply_icmp_checksum_o (reply_icmp_checksum_o)
  );

  always #5 clk_i = ~clk_i;

  verdict_t   verdict_q[$];
  logic [7:0] pkt_bytes[$];
  int         mismatches   = 0;
  int         results_seen = 0;
  int         cycles       = 0;
  int         reply_gap    = 0;
  int         hold_left    = 0;
  bit         tx_idle      = 1'b1;
  bit         rx_idle      = 1'b1;

  // Shadow of the block's packet state.
  int          seen;
  logic [7:0]  hdr[HdrBytes];
  logic [15:0] hdr_acc;
  logic [15:0] icmp_acc;
  logic [7:0]  pending_hi;
  logic [7:0]  lead[4];

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32'hffff) s = s - 32'hffff;
    return s[15:0];
  endfunction

  task automatic restart_packet();
    seen       = 0;
    hdr_acc    = '0;
    icmp_acc   = '0;
    pending_hi = '0;
    foreach (lead[k]) lead[k] = '0;
  endtask

  task automatic predict_verdict(input logic [7:0] b, input logic last);
    int          pos;
    int          tlen;
    int          hl;
    int          k;
    logic [31:0] src;
    logic [15:0] rest;
    logic [15:0] full;
    logic [15:0] ipchk;
    status_e     st;
    verdict_t    v;
    pos = seen;
    if (pos < HdrBytes) begin
      hdr[pos] = b;
      if (pos % 2 == 1) hdr_acc = ones_add(hdr_acc, {hdr[pos - 1], hdr[pos]});
    end else begin
      tlen = int'({hdr[2], hdr[3]});
      if (pos < tlen) begin
        k = pos - HdrBytes;
        if (k < 4) lead[k] = b;
        else if (k % 2 == 0) pending_hi = b;
        else icmp_acc = ones_add(icmp_acc, {pending_hi, b});
      end
    end
    if (seen < CountMax) seen++;
    if (!last) return;

    tlen = int'({hdr[2], hdr[3]});
    hl   = 4 * hdr[0][3:0];
    src  = {hdr[12], hdr[13], hdr[14], hdr[15]};
    rest = icmp_acc;
    // An odd ICMP part ends in a byte that is padded with a zero low byte.
    if (tlen >= HdrBytes + 5 && (tlen - HdrBytes) % 2 == 1)
      rest = ones_add(rest, {pending_hi, 8'h00});
    full = ones_add(rest, {lead[0], lead[1]});
    full = ones_add(full, {lead[2], lead[3]});

    if (seen < HdrBytes) st = StShort;
    else if (hdr[0][7:4] != IpVersion) st = StVersion;
    else if (tlen < hl + 8) st = StLen;
    else if (seen < tlen) st = StTrunc;
    else if (hl != HdrBytes) st = StHlen;
    else if (hdr_acc != 16'hffff) st = StIpSum;
    else if (hdr[9] != ProtoIcmp) st = StProto;
    else if ((hdr[6] | hdr[7]) != 8'h00) st = StFrag;
    else if (src == 32'hffff_ffff || src == 32'h0) st = StSrc;
    else if (src[31:28] == McastNibble) st = StMcast;
    else if (full != 16'hffff) st = StIcmpSum;
    else if (lead[0] != TypeEchoReq) st = StType;
    else if (lead[1] != 8'h00) st = StCode;
    else st = StOk;

    v = '0;
    v.status = st;
    if (st == StOk) begin
      ipchk = '0;
      for (k = 0; k < HdrBytes; k += 2)
        if (k != 10) ipchk = ones_add(ipchk, {hdr[k], hdr[k + 1]});
      v.src      = {hdr[16], hdr[17], hdr[18], hdr[19]};
      v.dst      = src;
      v.ip_chk   = ~ipchk;
      v.icmp_chk = ~ones_add(rest, {8'h00, lead[1]});
    end
    verdict_q.push_back(v);
    restart_packet();
  endtask

  function automatic logic [15:0] word_sum(input int from, input int upto);
    logic [15:0] acc;
    logic [7:0]  lo;
    int          k;
    acc = '0;
    for (k = from; k < upto; k += 2) begin
      lo  = (k + 1 < upto) ? pkt_bytes[k + 1] : 8'h00;
      acc = ones_add(acc, {pkt_bytes[k], lo});
    end
    return acc;
  endfunction

  task automatic put_field(input int idx, input logic [31:0] val, input int nbytes);
    int k;
    for (k = 0; k < nbytes; k++) pkt_bytes[idx + k] = val[8 * (nbytes - 1 - k) +: 8];
  endtask

  task automatic fix_ip_sum();
    put_field(10, 32'h0, 2);
    put_field(10, {16'h0, ~word_sum(0, HdrBytes)}, 2);
  endtask

  task automatic fix_icmp_sum();
    int tlen;
    tlen = int'({pkt_bytes[2], pkt_bytes[3]});
    put_field(22, 32'h0, 2);
    put_field(22, {16'h0, ~word_sum(HdrBytes, tlen)}, 2);
  endtask

  // Well-formed echo request with random content and plen payload bytes.
  task automatic build_echo(input int plen);
    int          tlen;
    logic [31:0] src;
    tlen = 28 + plen;
    src  = $urandom;
    while (src == 32'h0 || src == 32'hffff_ffff || src[31:28] == McastNibble) src = $urandom;
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h45);
    pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(tlen[15:8]);
    pkt_bytes.push_back(tlen[7:0]);
    repeat (2) pkt_bytes.push_back(8'($urandom));
    repeat (2) pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(ProtoIcmp);
    repeat (10) pkt_bytes.push_back(8'h00);
    put_field(12, src, 4);
    put_field(16, $urandom, 4);
    pkt_bytes.push_back(TypeEchoReq);
    repeat (3) pkt_bytes.push_back(8'h00);
    repeat (4 + plen) pkt_bytes.push_back(8'($urandom));
    fix_ip_sum();
    fix_icmp_sum();
  endtask

  task automatic trim_to(input int n);
    while (pkt_bytes.size() > n) pkt_bytes.delete(pkt_bytes.size() - 1);
  endtask

  task automatic make_packet(input flavor_e fl, input int plen);
    int         n;
    int         tlen;
    logic [7:0] v;
    build_echo(plen);
    tlen = 28 + plen;
    case (fl)
      PkTrailing: repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
      PkShort: trim_to($urandom_range(1, HdrBytes - 1));
      PkVersion: begin
        v = 8'($urandom_range(0, 14));
        if (v[3:0] >= IpVersion) v++;
        pkt_bytes[0] = {v[3:0], 4'h5};
        fix_ip_sum();
      end
      PkLen: begin
        put_field(2, $urandom_range(0, 27), 2);
        fix_ip_sum();
      end
      PkTrunc: trim_to($urandom_range(HdrBytes, tlen - 1));
      PkHlen: begin
        v = 8'($urandom_range(0, 5));
        if (v == 8'd5) v = 8'd6;
        pkt_bytes[0] = {IpVersion, v[3:0]};
        fix_ip_sum();
      end
      PkIpSum: begin
        n = $urandom_range(10, 19);
        pkt_bytes[n] ^= 8'($urandom_range(1, 255));
      end
      PkProto: begin
        v = 8'($urandom_range(0, 254));
        if (v >= ProtoIcmp) v++;
        pkt_bytes[9] = v;
        fix_ip_sum();
      end
      PkFrag: begin
        // A single set bit anywhere in flags and offset, DF included.
        put_field(6, 32'h1 << $urandom_range(0, 15), 2);
        fix_ip_sum();
      end
      PkSrc: begin
        put_field(12, $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, 4);
        fix_ip_sum();
      end
      PkMcast: begin
        pkt_bytes[12] = {McastNibble, 4'($urandom)};
        fix_ip_sum();
      end
      PkIcmpSum: begin
        n = $urandom_range(HdrBytes, tlen - 1);
        pkt_bytes[n] ^= 8'($urandom_range(1, 255));
      end
      PkType: begin
        v = 8'($urandom_range(0, 254));
        if (v >= TypeEchoReq) v++;
        pkt_bytes[20] = v;
        fix_icmp_sum();
      end
      PkCode: begin
        pkt_bytes[21] = 8'($urandom_range(1, 255));
        fix_icmp_sum();
      end
      PkNoise: begin
        n = $urandom_range(1, 60);
        pkt_bytes.delete();
        repeat (n) pkt_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1)) pkt_bytes[0] = 8'h45;
      end
      default: ;
    endcase
  endtask

  // Valid stays high between back-to-back words; it drops only for a gap.
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_verdict(b, last);
  endtask

  task automatic send_packet();
    int k;
    for (k = 0; k < pkt_bytes.size(); k++) send_word(pkt_bytes[k], k == pkt_bytes.size() - 1);
  endtask

  // Receiver side: a long hold-off when asked, otherwise a short random pause
  // after each accepted word.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (reply_gap > 0) begin
      out_stall_i <= 1'b1;
      reply_gap--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_reply
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      reply_gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (verdict_q.size() == 0) begin
        $display("%0t: result word with none expected, status %0d", $time, status_o);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, status_o);
          mismatches++;
        end
        if (reply_source_o !== want.src) begin
          $display("%0t: reply_source expected %h, actual %h", $time, want.src,
                   reply_source_o);
          mismatches++;
        end
        if (reply_destination_o !== want.dst) begin
          $display("%0t: reply_destination expected %h, actual %h", $time, want.dst,
                   reply_destination_o);
          mismatches++;
        end
        if (reply_ip_checksum_o !== want.ip_chk) begin
          $display("%0t: reply_ip_checksum expected %h, actual %h", $time, want.ip_chk,
                   reply_ip_checksum_o);
          mismatches++;
        end
        if (reply_icmp_checksum_o !== want.icmp_chk) begin
          $display("%0t: reply_icmp_checksum expected %h, actual %h", $time, want.icmp_chk,
                   reply_icmp_checksum_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_icmp_echo_responder: FAIL");
      $finish;
    end
  end

  task automatic test_echo_replies();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    make_packet(PkEcho, 0);
    send_packet();
    // Odd ICMP lengths exercise the zero padding of the last byte.
    make_packet(PkEcho, 1);
    send_packet();
    make_packet(PkEcho, 7);
    send_packet();
    make_packet(PkTrailing, 2);
    send_packet();
    build_echo(4);
    put_field(12, 32'hffff_fffe, 4);
    put_field(16, 32'h0, 4);
    fix_ip_sum();
    send_packet();
    build_echo(3);
    put_field(12, 32'h0000_0001, 4);
    put_field(16, 32'hffff_ffff, 4);
    fix_ip_sum();
    send_packet();
  endtask

  task automatic test_check_order();
    int k;
    rx_idle = 1'b0;
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h45);
    send_packet();
    for (k = PkShort; k <= PkCode; k++) begin
      make_packet(flavor_e'(k), 6);
      send_packet();
    end
    rx_idle = 1'b1;
  endtask

  task automatic test_extreme_bytes();
    pkt_bytes.delete();
    repeat (30) pkt_bytes.push_back(8'h00);
    send_packet();
    pkt_bytes.delete();
    repeat (30) pkt_bytes.push_back(8'hff);
    send_packet();
    pkt_bytes.delete();
    pkt_bytes.push_back(8'hff);
    send_packet();
  endtask

  task automatic test_output_backpressure();
    tx_idle   = 1'b0;
    hold_left = LongHold;
    repeat (4) begin
      make_packet(PkEcho, $urandom_range(0, 4));
      send_packet();
    end
    tx_idle = 1'b1;
  endtask

  task automatic test_random_packets();
    int      first;
    int      sent;
    int      plen;
    flavor_e fl;
    first = results_seen;
    sent  = 0;
    while (sent < RandBytes || results_seen - first < RandReplies) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1)) fl = PkEcho;
      else fl = flavor_e'($urandom_range(PkTrailing, PkNoise));
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(0, 16);
      make_packet(fl, plen);
      sent += pkt_bytes.size();
      send_packet();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    out_stall_i = 1'b0;
    restart_packet();
    foreach (hdr[k]) hdr[k] = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_echo_replies();
    test_check_order();
    test_extreme_bytes();
    test_output_backpressure();
    test_random_packets();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) $display("tb_icmp_echo_responder: PASS");
    else $display("tb_icmp_echo_responder: FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ier_pkg.sv
rtl/ier_accum.sv
rtl/ier_verdict.sv
rtl/icmp_echo_responder.sv
dv/tb_icmp_echo_responder.sv
